// File: rtl/core/okm_pkg.sv
// Package for the online k-means nearest-centroid block.
// Holds sizes, opcodes, state type and the square-root request and response structs; no dependencies.
package okm_pkg;
  localparam int MAX_CLUSTERS = 8;
  localparam int MAX_POINTS = 1024;
  localparam int SLOT_W = $clog2(MAX_CLUSTERS);
  localparam int PIDX_W = $clog2(MAX_POINTS);
  localparam int SQ_W = 34;
  localparam int DIST_W = 18;
  localparam int SQRT_STEPS = 18;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TRAIN = 2'd1;
  localparam logic [1:0] OP_CLASSIFY = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_SQRT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [SQ_W-1:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic done;
    logic [DIST_W-1:0] root;
  } sqrt_rsp_t;
endpackage

// File: rtl/core/okm_sqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on okm_pkg.
module okm_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  okm_pkg::sqrt_req_t      req,
  output okm_pkg::sqrt_rsp_t      rsp
);
  localparam int RW = okm_pkg::SQ_W + 2;
  logic [RW-1:0] rem;
  logic [RW-1:0] res;
  logic [RW-1:0] bitv;
  logic busy;
  logic done;
  logic [RW-1:0] trial;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem <= {2'b00, req.value};
        res <= '0;
        bitv <= RW'(1) << (2 * (okm_pkg::SQRT_STEPS - 1));
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == RW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.root = res[okm_pkg::DIST_W-1:0];
  end
endmodule

// File: rtl/core/okm_label_mem.sv
// Label memory, each word a valid bit and a label, registered read.
// Cleared by one pass over all entries after reset. Depends on okm_pkg.
module okm_label_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [okm_pkg::PIDX_W-1:0]    rd_addr,
  output logic [okm_pkg::SLOT_W-1:0]    rd_label,
  output logic                          rd_valid,
  input  logic                          wr_en,
  input  logic [okm_pkg::PIDX_W-1:0]    wr_addr,
  input  logic [okm_pkg::SLOT_W-1:0]    wr_label,
  output logic                          clearing
);
  logic [okm_pkg::SLOT_W:0] mem [okm_pkg::MAX_POINTS];
  logic [okm_pkg::SLOT_W:0] rd_word;
  logic [okm_pkg::PIDX_W-1:0] clr_addr;
  logic clr_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + okm_pkg::PIDX_W'(1);
      if (clr_addr == okm_pkg::PIDX_W'(okm_pkg::MAX_POINTS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= {1'b1, wr_label};
    end
    rd_word <= mem[rd_addr];
  end

  assign rd_label = rd_word[okm_pkg::SLOT_W-1:0];
  assign rd_valid = rd_word[okm_pkg::SLOT_W];
  assign clearing = clr_busy;
endmodule

// File: rtl/core/online_kmeans_nearest_centroid.sv
// Online k-means nearest-centroid engine, top level.
// Load: result registered straight from the input transfer; train/classify read one
// centroid per cycle over active_clusters (clamped to 1..8), then an 18-step square root.
// One item in flight; next item accepted the cycle after its result transfers.
// Reset: synchronous; centroids read as zero until written; label memory cleared
// by one pass over all entries after reset with input held off. Depends on okm_pkg, okm_sqrt, okm_label_mem.
module online_kmeans_nearest_centroid (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [3:0]                           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           opcode,
  input  logic [2:0]                           centroid_slot,
  input  logic [9:0]                           point_index,
  input  logic signed [15:0]                   coord_x,
  input  logic signed [15:0]                   coord_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           cluster,
  output logic [17:0]                          distance,
  output logic                                 label_changed
);
  localparam int SW = okm_pkg::SLOT_W;
  localparam int CW = SW + 1;

  okm_pkg::state_t state, state_next;
  logic [3:0] active_clusters;
  logic [CW-1:0] n_act;

  logic [1:0] op;
  logic [okm_pkg::PIDX_W-1:0] pidx;
  logic signed [15:0] px, py;

  // centroid memory, x and y packed in one word
  logic [31:0] cmem [okm_pkg::MAX_CLUSTERS];
  logic [okm_pkg::MAX_CLUSTERS-1:0] cvalid;
  logic [31:0] crd;
  logic crd_v;
  logic [SW-1:0] rd_addr;
  logic c_we;
  logic [SW-1:0] c_waddr;
  logic [31:0] c_wdata;

  logic [CW-1:0] issue_cnt;
  logic [CW-1:0] cmp_cnt;
  logic rd_pend;
  logic [SW-1:0] rd_slot;
  logic [okm_pkg::SQ_W-1:0] best_sq;
  logic [SW-1:0] best;
  logic [31:0] best_c;

  logic signed [16:0] dx, dy;
  logic [16:0] ax, ay;
  logic [okm_pkg::SQ_W-1:0] sq;
  logic signed [15:0] cx, cy;
  logic signed [16:0] sx, sy;

  okm_pkg::sqrt_req_t sreq;
  okm_pkg::sqrt_rsp_t srsp;
  logic [SW-1:0] lbl_q;
  logic lbl_v;
  logic lbl_we;
  logic lbl_clearing;
  logic pidx_ok;

  logic [2:0] r_cluster;
  logic [17:0] r_dist;
  logic r_changed;
  logic r_valid;
  logic in_xfer;

  function automatic logic [okm_pkg::SQ_W-1:0] SQ_W_sum(input logic [16:0] a,
                                                        input logic [16:0] b);
    logic [okm_pkg::SQ_W-1:0] pa;
    logic [okm_pkg::SQ_W-1:0] pb;
    pa = {17'd0, a} * {17'd0, a};
    pb = {17'd0, b} * {17'd0, b};
    return pa + pb;
  endfunction

  always_comb begin
    if (active_clusters == 4'd0) begin
      n_act = CW'(1);
    end else if (active_clusters > 4'(okm_pkg::MAX_CLUSTERS)) begin
      n_act = CW'(okm_pkg::MAX_CLUSTERS);
    end else begin
      n_act = CW'(active_clusters);
    end
  end

  assign in_ready = (state == okm_pkg::ST_IDLE) && !r_valid && !lbl_clearing;
  assign in_xfer = in_valid && in_ready;
  assign pidx_ok = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_clusters <= 4'd8;
    end else if (cfg_we) begin
      active_clusters <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    crd <= cmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid <= '0;
      crd_v <= 1'b0;
    end else begin
      if (c_we) begin
        cvalid[c_waddr] <= 1'b1;
      end
      crd_v <= cvalid[rd_addr];
    end
  end

  assign rd_addr = issue_cnt[SW-1:0];
  assign cx = crd_v ? crd[31:16] : 16'sd0;
  assign cy = crd_v ? crd[15:0] : 16'sd0;
  assign dx = 17'(px) - 17'(cx);
  assign dy = 17'(py) - 17'(cy);
  assign ax = dx[16] ? 17'(-dx) : 17'(dx);
  assign ay = dy[16] ? 17'(-dy) : 17'(dy);
  assign sq = SQ_W_sum(ax, ay);

  assign sx = 17'(signed'(best_c[31:16])) + 17'(px);
  assign sy = 17'(signed'(best_c[15:0])) + 17'(py);

  always_comb begin
    c_we = 1'b0;
    c_waddr = best;
    c_wdata = {sx[16:1], sy[16:1]};
    if (in_xfer && opcode == okm_pkg::OP_LOAD) begin
      c_we = 1'b1;
      c_waddr = centroid_slot;
      c_wdata = {coord_x, coord_y};
    end else if (state == okm_pkg::ST_UPDATE && op == okm_pkg::OP_TRAIN) begin
      c_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    sreq.start = 1'b0;
    sreq.value = best_sq;
    lbl_we = 1'b0;
    unique case (state)
      okm_pkg::ST_IDLE: begin
        if (in_xfer && (opcode == okm_pkg::OP_TRAIN || opcode == okm_pkg::OP_CLASSIFY)) begin
          state_next = okm_pkg::ST_SEARCH;
        end
      end
      okm_pkg::ST_SEARCH: begin
        if (rd_pend && (cmp_cnt + CW'(1) == n_act)) begin
          state_next = okm_pkg::ST_UPDATE;
        end
      end
      okm_pkg::ST_UPDATE: begin
        sreq.start = 1'b1;
        lbl_we = (op == okm_pkg::OP_CLASSIFY) && pidx_ok;
        state_next = okm_pkg::ST_SQRT;
      end
      okm_pkg::ST_SQRT: begin
        if (srsp.done) begin
          state_next = okm_pkg::ST_IDLE;
        end
      end
      okm_pkg::ST_OUT: begin
        state_next = okm_pkg::ST_IDLE;
      end
      default: state_next = okm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= okm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      cmp_cnt <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (in_xfer) begin
        issue_cnt <= '0;
        cmp_cnt <= '0;
        rd_pend <= 1'b0;
      end else if (state == okm_pkg::ST_SEARCH) begin
        rd_pend <= issue_cnt < n_act;
        if (issue_cnt < n_act) begin
          issue_cnt <= issue_cnt + CW'(1);
        end
        if (rd_pend) begin
          cmp_cnt <= cmp_cnt + CW'(1);
        end
      end else begin
        rd_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= rd_addr;
    if (in_xfer) begin
      op <= opcode;
      pidx <= point_index;
      px <= coord_x;
      py <= coord_y;
    end
    if (state == okm_pkg::ST_SEARCH && rd_pend) begin
      if (cmp_cnt == '0 || sq <= best_sq) begin
        best_sq <= sq;
        best <= rd_slot;
        best_c <= {cx, cy};
      end
    end
  end

  okm_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

  okm_label_mem u_label (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (pidx),
    .rd_label (lbl_q),
    .rd_valid (lbl_v),
    .wr_en    (lbl_we),
    .wr_addr  (pidx),
    .wr_label (best),
    .clearing (lbl_clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        r_valid <= 1'b0;
      end
      if (in_xfer && opcode == okm_pkg::OP_LOAD) begin
        r_valid <= 1'b1;
      end else if (state == okm_pkg::ST_SQRT && srsp.done) begin
        r_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && opcode == okm_pkg::OP_LOAD) begin
      r_cluster <= centroid_slot;
      r_dist <= '0;
      r_changed <= 1'b0;
    end else if (state == okm_pkg::ST_UPDATE) begin
      r_cluster <= best;
      r_changed <= (op == okm_pkg::OP_CLASSIFY) && (!lbl_v || lbl_q != best);
    end else if (state == okm_pkg::ST_SQRT && srsp.done) begin
      r_dist <= srsp.root;
    end
  end

  assign out_valid = r_valid;
  assign cluster = r_cluster;
  assign distance = r_dist;
  assign label_changed = r_changed;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_xfer && opcode != okm_pkg::OP_UNUSED |=> !in_ready) else $error("accepted while busy");
  a_done_in_sqrt: assert property (@(posedge clk) disable iff (rst)
    srsp.done |-> state == okm_pkg::ST_SQRT) else $error("stray sqrt done");
  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    state == okm_pkg::ST_SEARCH |-> cmp_cnt < n_act) else $error("search overrun");
endmodule

// File: verif/tb_online_kmeans_nearest_centroid.sv
// Testbench for online_kmeans_nearest_centroid: random and directed load/train/classify
// traffic checked against an in-bench centroid and label predictor. Needs okm_pkg and the RTL.
`timescale 1ns / 1ps

module tb_online_kmeans_nearest_centroid;
  typedef struct {
    logic [1:0] op;
    logic [2:0] slot;
    logic [9:0] pidx;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_item_t;

  typedef struct {
    logic [2:0] cl;
    logic [17:0] dval;
    logic chg;
  } match_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [3:0] cfg_wdata = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] opcode = 0;
  logic [2:0] centroid_slot = 0;
  logic [9:0] point_index = 0;
  logic signed [15:0] coord_x = 0;
  logic signed [15:0] coord_y = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [2:0] cluster;
  logic [17:0] distance;
  logic label_changed;

  online_kmeans_nearest_centroid dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .centroid_slot(centroid_slot), .point_index(point_index),
    .coord_x(coord_x), .coord_y(coord_y), .out_valid(out_valid),
    .out_ready(out_ready), .cluster(cluster), .distance(distance),
    .label_changed(label_changed)
  );

  point_item_t pending_pts[$];
  match_t expected_matches[$];
  point_item_t cur;
  logic taken = 0;
  bit calm = 0;
  int errors = 0;

  logic signed [15:0] cent_x [okm_pkg::MAX_CLUSTERS];
  logic signed [15:0] cent_y [okm_pkg::MAX_CLUSTERS];
  logic [2:0] labels [okm_pkg::MAX_POINTS];
  bit label_set [okm_pkg::MAX_POINTS];
  logic [3:0] active_cnt = 4'd8;

  initial forever #5 clk = ~clk;

  function automatic logic [17:0] floor_root(logic [33:0] v);
    longint r;
    longint t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= longint'(v)) r = t;
    end
    return r[17:0];
  endfunction

  function automatic logic [33:0] sq_to(point_item_t it, int s);
    longint dx;
    longint dy;
    dx = longint'(it.x) - longint'(cent_x[s]);
    dy = longint'(it.y) - longint'(cent_y[s]);
    return 34'(dx * dx + dy * dy);
  endfunction

  // update centroid/label state for one transfer and queue its result; unused opcodes queue nothing
  task automatic predict_point(point_item_t it);
    int n;
    int best;
    logic [33:0] bd;
    logic [33:0] d;
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    match_t m;
    if (it.op == okm_pkg::OP_UNUSED) return;
    m.chg = 0;
    m.dval = 0;
    if (it.op == okm_pkg::OP_LOAD) begin
      cent_x[it.slot] = it.x;
      cent_y[it.slot] = it.y;
      m.cl = it.slot;
    end else begin
      n = (active_cnt == 0) ? 1 :
          (active_cnt > okm_pkg::MAX_CLUSTERS ? okm_pkg::MAX_CLUSTERS : active_cnt);
      best = 0;
      bd = sq_to(it, 0);
      for (int s = 1; s < n; s++) begin
        d = sq_to(it, s);
        if (d <= bd) begin
          bd = d;
          best = s;
        end
      end
      m.cl = best[2:0];
      m.dval = floor_root(bd);
      if (it.op == okm_pkg::OP_TRAIN) begin
        sx = 17'(cent_x[best]) + 17'(it.x);
        sy = 17'(cent_y[best]) + 17'(it.y);
        cent_x[best] = 16'(sx >>> 1);
        cent_y[best] = 16'(sy >>> 1);
      end else begin
        m.chg = !label_set[it.pidx] || labels[it.pidx] != best[2:0];
        labels[it.pidx] = best[2:0];
        label_set[it.pidx] = 1;
      end
    end
    expected_matches.push_back(m);
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready && !taken) begin
      predict_point(cur);
      taken = 1;
    end
  end

  always @(negedge clk) begin
    if (!rst && !(in_valid && !taken)) begin
      if (pending_pts.size() > 0 && (calm || $urandom_range(99) >= 12)) begin
        cur = pending_pts.pop_front();
        opcode <= cur.op;
        centroid_slot <= cur.slot;
        point_index <= cur.pidx;
        coord_x <= cur.x;
        coord_y <= cur.y;
        taken = 0;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
    out_ready <= !rst && (calm || $urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    match_t m;
    if (!rst && out_valid && out_ready) begin
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected result cluster=%0d distance=%0d changed=%0d",
                 $time, cluster, distance, label_changed);
        errors++;
      end else begin
        m = expected_matches.pop_front();
        if (cluster !== m.cl) begin
          $display("%0t: cluster expected %0d actual %0d", $time, m.cl, cluster);
          errors++;
        end
        if (distance !== m.dval) begin
          $display("%0t: distance expected %0d actual %0d", $time, m.dval, distance);
          errors++;
        end
        if (label_changed !== m.chg) begin
          $display("%0t: label_changed expected %0d actual %0d", $time, m.chg,
                   label_changed);
          errors++;
        end
      end
    end
  end

  task automatic push_pt(logic [1:0] op, logic [2:0] slot, logic [9:0] pidx,
                         logic [15:0] x, logic [15:0] y);
    point_item_t it;
    it.op = op;
    it.slot = slot;
    it.pidx = pidx;
    it.x = x;
    it.y = y;
    pending_pts.push_back(it);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(8)) - 16'd4;
      2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(2047)) - 16'd1024;
    endcase
  endfunction

  task automatic drain();
    while (pending_pts.size() > 0 || (in_valid && !taken) || expected_matches.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_active(logic [3:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    active_cnt = v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    logic [3:0] cfg_plan [7];
    int r;
    foreach (cent_x[i]) begin
      cent_x[i] = 0;
      cent_y[i] = 0;
    end
    foreach (label_set[i]) label_set[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, ties, label change and repeat, unused opcode
    push_pt(okm_pkg::OP_CLASSIFY, 0, 0, 0, 0);
    push_pt(okm_pkg::OP_LOAD, 0, 0, 16'h7fff, 16'h7fff);
    push_pt(okm_pkg::OP_LOAD, 7, 0, 16'h8000, 16'h8000);
    push_pt(okm_pkg::OP_CLASSIFY, 0, 10'd1023, 16'h8000, 16'h7fff);
    push_pt(okm_pkg::OP_CLASSIFY, 0, 10'd1023, 16'h8000, 16'h7fff);
    push_pt(okm_pkg::OP_CLASSIFY, 0, 10'd1023, 16'h7fff, 16'h7fff);
    push_pt(okm_pkg::OP_LOAD, 3, 0, 16'd10, 0);
    push_pt(okm_pkg::OP_LOAD, 5, 0, 16'hfff6, 0);
    push_pt(okm_pkg::OP_CLASSIFY, 0, 10'd5, 0, 0);
    push_pt(okm_pkg::OP_TRAIN, 0, 0, 0, 16'd1);
    push_pt(okm_pkg::OP_UNUSED, 0, 0, 16'd1, 16'd1);
    push_pt(okm_pkg::OP_TRAIN, 0, 0, 16'h8000, 16'h8000);
    push_pt(okm_pkg::OP_TRAIN, 0, 0, 16'hffff, 16'hfffd);
    push_pt(okm_pkg::OP_CLASSIFY, 0, 10'd5, 16'h7fff, 16'h8000);
    push_pt(okm_pkg::OP_LOAD, 2, 10'h3ff, 16'h0101, 16'hfefe);
    push_pt(okm_pkg::OP_CLASSIFY, 0, 10'h2aa, 16'h0100, 16'hff00);
    drain();

    cfg_plan = '{4'd0, 4'd1, 4'd15, 4'd8, 4'd2, 4'd5, 4'd8};
    cfg_plan[6] = 4'($urandom);
    for (int p = 0; p < 7; p++) begin
      write_active(cfg_plan[p]);
      calm = (p == 3);
      for (int i = 0; i < 200; i++) begin
        r = $urandom_range(99);
        if (r < 12)
          push_pt(okm_pkg::OP_LOAD, 3'($urandom), 10'($urandom), pick_coord(),
                  pick_coord());
        else if (r < 50)
          push_pt(okm_pkg::OP_TRAIN, 3'($urandom), 10'($urandom), pick_coord(),
                  pick_coord());
        else if (r < 97)
          push_pt(okm_pkg::OP_CLASSIFY, 3'($urandom),
                  $urandom_range(1) ? 10'($urandom_range(15)) : 10'($urandom),
                  pick_coord(), pick_coord());
        else
          push_pt(okm_pkg::OP_UNUSED, 3'($urandom), 10'($urandom), pick_coord(),
                  pick_coord());
      end
      drain();
    end
    calm = 0;

    if (errors == 0 && expected_matches.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end
endmodule
